// ===== design/assert_macros.svh =====
// Assertion macros shared by the trajectory unit RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define TLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/tlt_pkg.sv =====
// Shared types and constants of the trapezoid line trajectory unit.
// No dependencies; used by the interfaces, the divider and the top level.
package tlt_pkg;

  // Width of the long divider quotient and divisor.
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_LEN = 3'd6;
  // Index with no register behind it; writes to it are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;

  // Largest ramp share that is latched: one half in Q0.16.
  localparam logic [15:0] RAMP_CAP = 16'h8000;

  // Request to the shared divider: 128 bit dividend, 64 bit divisor.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num_hi;
    logic [DIV_W-1:0] num_lo;
    logic [DIV_W-1:0] den;
  } div_req_t;

  // Divider status and saturated quotient.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== design/tlt_if.sv =====
// Channel interfaces of the trapezoid line trajectory unit.
// Depends on tlt_pkg for the configuration index width.
interface tlt_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface tlt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [15:0] dir_x;
  logic [15:0] dir_y;
  logic [31:0] path_pos;
  logic [31:0] path_speed;
  logic [31:0] move_time;
  modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                  output dir_x, output dir_y, output path_pos, output path_speed,
                  output move_time, input ready);
  modport sink (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                input dir_x, input dir_y, input path_pos, input path_speed,
                input move_time, output ready);
endinterface

interface tlt_cfg_if
  import tlt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/tlt_div.sv =====
// Restoring divider, one quotient bit per cycle, 128 by 64 bit, saturating.
// Depends on tlt_pkg for the request and response structs.
module tlt_div import tlt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     lo;
  logic [DIV_W-1:0]     den;
  logic [DIV_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;

  // One restoring step: shift in the next dividend bit and try the divisor.
  logic             carry;
  logic [DIV_W-1:0] shifted;
  logic             take;
  logic [DIV_W-1:0] diff;

  assign carry   = rem[DIV_W-1];
  assign shifted = {rem[DIV_W-2:0], lo[DIV_W-1]};
  assign take    = carry || (shifted >= den);
  assign diff    = shifted - den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        // A zero divisor or a quotient beyond 64 bits saturates at once.
        if ((req.den == '0) || (req.num_hi >= req.den)) begin
          quo  <= '1;
          done <= 1'b1;
        end else begin
          rem  <= req.num_hi;
          lo   <= req.num_lo;
          den  <= req.den;
          quo  <= '0;
          cnt  <= '0;
          busy <= 1'b1;
          done <= 1'b0;
        end
      end else if (busy) begin
        rem <= take ? diff : shifted;
        lo  <= {lo[DIV_W-2:0], 1'b0};
        quo <= {quo[DIV_W-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp = '{busy: busy, done: done, quo: quo};

endmodule

// ===== design/trapezoid_line_trajectory_unit.sv =====
// Top level of the trapezoid line trajectory unit: sequencer, shared multiplier.
// Depends on tlt_pkg, the channel interfaces, tlt_div and assert_macros.svh.
//
// Usage. The cmd channel takes one control tick per transaction; restart = 1
// starts a new move at time zero, measuring the start-to-end distance and
// latching the ramp share. The rsp channel returns one transaction per tick:
// position, velocity, unit direction, path distance, path speed and move time.
// The cfg channel writes the seven registers by index; it is always ready and
// is meant to be written only while no tick is in flight.
// Sequence. The divider serves the move time, the ramp speed and six
// projections one after another, and a 32 bit multiplier serves every product,
// the low and the high half of its 64 bit operand in turn. A restart tick adds
// the squares and the 32 step square root. When the speed is zero the profile
// part is skipped; when the distance is zero the divider returns at once.
// Throughput. One tick at a time; cmd.ready is high only when the sequencer is
// idle. A finished result sits in the output register, so the next tick can
// be taken while rsp is stalled; that tick waits at its end until the output
// register frees up.
// Reset. rst clears the registers, the tick counter, the latched length and
// ramp share, and empties the output register.
`include "assert_macros.svh"

module trapezoid_line_trajectory_unit import tlt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  tlt_in_if.sink    cmd,
  tlt_out_if.source rsp,
  tlt_cfg_if.sink   cfg
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQY, S_SUM, S_ROOT, S_TICK, S_GV, S_TF, S_TR, S_PHASE,
    S_UP1, S_UP2, S_UP3, S_CONST, S_DN1, S_DN2, S_DN3, S_DN4,
    S_PROJ, S_PDIV, S_PWB, S_DONE, S_ML, S_MH, S_MA, S_DW
  } state_t;

  // Configuration registers.
  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic [31:0]        max_speed;
  logic [15:0]        ramp_share;
  logic [31:0]        tick_length;

  // Move state.
  logic [31:0] tick_count;
  logic [31:0] path_len;
  logic [15:0] ramp_lat;

  // Sequencer and working registers.
  state_t      state;
  state_t      ret;
  logic [31:0] op_a;
  logic [63:0] op_b;
  logic [63:0] mp;
  logic [95:0] acc;
  logic [63:0] qx;
  logic [63:0] rx;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [63:0] t;
  logic [63:0] tf;
  logic [63:0] tr;
  logic [63:0] tc;
  logic [63:0] sreg;
  logic [63:0] full;
  logic [31:0] pp;
  logic [31:0] sp;
  logic [2:0]  job;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Results of the tick and the output register.
  logic [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y;
  logic [15:0] r_dir_x, r_dir_y;
  logic        out_valid;
  logic [31:0] o_pos_x, o_pos_y, o_vel_x, o_vel_y;
  logic [15:0] o_dir_x, o_dir_y;
  logic [31:0] o_path_pos, o_path_speed, o_move_time;

  tlt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Start-to-end differences and their magnitudes.
  logic [32:0] dx, dy;
  logic [31:0] sx, sy;
  assign dx = {end_x[31], end_x} - {start_x[31], start_x};
  assign dy = {end_y[31], end_y} - {start_y[31], start_y};
  assign sx = dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
  assign sy = dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];

  // Shared multiplier: the low or the high half of op_b per pass.
  logic [31:0] mul_part;
  logic [63:0] mul_out;
  assign mul_part = (state == S_ML) ? op_b[31:0] : op_b[63:32];
  assign mul_out  = op_a * mul_part;

  // Square root step.
  logic [63:0] root_try;
  logic        root_ge;
  logic [63:0] res_nx;
  assign root_try = res + bitm;
  assign root_ge  = rx >= root_try;
  assign res_nx   = root_ge ? ((res >> 1) + bitm) : (res >> 1);

  // Sum of squares with overflow bit.
  logic [64:0] sum65;
  assign sum65 = {1'b0, qx} + {1'b0, acc[63:0]};

  // Profile phase boundaries.
  logic [63:0] tr_w, tc_w;
  assign tr_w = acc[79:16];
  assign tc_w = tf - tr_w;

  // Path position before the clamp to the length.
  logic [63:0] dec;
  logic [63:0] pp_raw;
  logic [31:0] pp_clamped;
  assign dec = {1'b0, acc[95:33]};
  always_comb begin
    unique case (state)
      S_UP3:   pp_raw = {1'b0, acc[95:33]};
      S_CONST: pp_raw = acc[95:32];
      S_DN4:   pp_raw = (full > dec) ? (full - dec) : 64'd0;
      default: pp_raw = 64'd0;
    endcase
  end
  assign pp_clamped = (pp_raw > {32'd0, path_len}) ? path_len : pp_raw[31:0];

  // Projection onto the axes, selected by the job index.
  logic               d_neg;
  logic [31:0]        d_abs;
  logic [31:0]        start_sel;
  logic [63:0]        q_eff;
  logic [33:0]        proj_mag;
  logic [35:0]        pmag36;
  logic signed [35:0] proj_val;
  logic signed [35:0] pos_sum;
  logic [15:0]        unit_val;

  assign d_neg     = job[0] ? dy[32] : dx[32];
  assign d_abs     = job[0] ? sy : sx;
  assign start_sel = job[0] ? start_y : start_x;
  assign q_eff     = (path_len == '0) ? 64'd0 : div_rsp.quo;
  assign proj_mag  = (q_eff > 64'h2_0000_0000) ? 34'h2_0000_0000 : q_eff[33:0];
  assign pmag36    = {2'b00, proj_mag};
  assign proj_val  = d_neg ? -$signed(pmag36) : $signed(pmag36);
  assign pos_sum   = $signed({{4{start_sel[31]}}, start_sel}) + proj_val;

  always_comb begin
    if (d_neg) begin
      unit_val = (q_eff > 64'd32768) ? 16'h8000 : (~q_eff[15:0] + 16'd1);
    end else begin
      unit_val = (q_eff > 64'd32767) ? 16'h7FFF : q_eff[15:0];
    end
  end

  // Configuration writes.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      end_x       <= '0;
      end_y       <= '0;
      max_speed   <= '0;
      ramp_share  <= '0;
      tick_length <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_X:  start_x     <= cfg.data;
        REG_START_Y:  start_y     <= cfg.data;
        REG_END_X:    end_x       <= cfg.data;
        REG_END_Y:    end_y       <= cfg.data;
        REG_MAX_SPD:  max_speed   <= cfg.data;
        REG_RAMP:     ramp_share  <= cfg.data[15:0];
        REG_TICK_LEN: tick_length <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);

  // Sequencer: multiplier and divider calls return to the state in ret.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret           <= S_IDLE;
      div_req.start <= 1'b0;
      out_valid     <= 1'b0;
      tick_count    <= '0;
      path_len      <= '0;
      ramp_lat      <= '0;
    end else begin
      // Divider start pulse, one cycle in each state that issues a request.
      div_req.start <= (state == S_TF) || (state == S_UP1) || (state == S_DN1) ||
                       (state == S_PDIV) || ((state == S_PROJ) && job[2]);

      // Output register: loaded when a tick finishes, freed when taken.
      if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.restart) begin
              op_a  <= sx;
              op_b  <= {32'd0, sx};
              ret   <= S_SQY;
              state <= S_ML;
            end else begin
              state <= S_TICK;
            end
          end
        end
        S_SQY: begin
          qx    <= acc[63:0];
          op_a  <= sy;
          op_b  <= {32'd0, sy};
          ret   <= S_SUM;
          state <= S_ML;
        end
        S_SUM: begin
          tick_count <= '0;
          ramp_lat   <= (ramp_share > RAMP_CAP) ? RAMP_CAP : ramp_share;
          if (sum65[64]) begin
            path_len <= '1;
            state    <= S_TICK;
          end else begin
            rx    <= sum65[63:0];
            res   <= '0;
            bitm  <= 64'h4000_0000_0000_0000;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_ge) begin
            rx <= rx - root_try;
          end
          res  <= res_nx;
          bitm <= bitm >> 2;
          if (bitm[0]) begin
            path_len <= res_nx[31:0];
            state    <= S_TICK;
          end
        end
        S_TICK: begin
          op_a  <= tick_length;
          op_b  <= {32'd0, tick_count};
          ret   <= S_GV;
          state <= S_ML;
        end
        S_GV: begin
          t   <= acc[63:0];
          job <= '0;
          if ((path_len == '0) || (max_speed == '0)) begin
            pp    <= '0;
            sp    <= '0;
            tf    <= '0;
            state <= S_PROJ;
          end else begin
            op_a  <= max_speed;
            op_b  <= {48'd0, ramp_lat};
            ret   <= S_TF;
            state <= S_ML;
          end
        end
        S_TF: begin
          // Divisor (65536 - f) * v, dividend L * 2^48.
          div_req.num_hi <= {48'd0, path_len[31:16]};
          div_req.num_lo <= {path_len[15:0], 48'd0};
          div_req.den    <= {15'd0, ({max_speed, 16'd0} - acc[48:0])};
          ret            <= S_TR;
          state          <= S_DW;
        end
        S_TR: begin
          tf    <= div_rsp.quo;
          op_a  <= {16'd0, ramp_lat};
          op_b  <= div_rsp.quo;
          ret   <= S_PHASE;
          state <= S_ML;
        end
        S_PHASE: begin
          tr <= tr_w;
          tc <= tc_w;
          if (t < tr_w) begin
            // Ramp-up.
            op_a  <= max_speed;
            op_b  <= t;
            ret   <= S_UP1;
            state <= S_ML;
          end else if (t <= tc_w) begin
            // Constant speed.
            sp    <= max_speed;
            op_a  <= max_speed;
            op_b  <= t - (tr_w >> 1);
            ret   <= S_CONST;
            state <= S_ML;
          end else if (t <= tf) begin
            // Ramp-down.
            sreg  <= tf - t;
            op_a  <= max_speed;
            op_b  <= tf - t;
            ret   <= S_DN1;
            state <= S_ML;
          end else begin
            // Hold at the end point.
            sp    <= '0;
            pp    <= path_len;
            state <= S_PROJ;
          end
        end
        S_UP1, S_DN1: begin
          div_req.num_hi <= {32'd0, acc[95:64]};
          div_req.num_lo <= acc[63:0];
          div_req.den    <= tr;
          ret            <= (state == S_UP1) ? S_UP2 : S_DN2;
          state          <= S_DW;
        end
        S_UP2: begin
          sp    <= div_rsp.quo[31:0];
          op_a  <= div_rsp.quo[31:0];
          op_b  <= t;
          ret   <= S_UP3;
          state <= S_ML;
        end
        S_DN2: begin
          sp    <= div_rsp.quo[31:0];
          op_a  <= max_speed;
          op_b  <= tc;
          ret   <= S_DN3;
          state <= S_ML;
        end
        S_DN3: begin
          full  <= acc[95:32];
          op_a  <= sp;
          op_b  <= sreg;
          ret   <= S_DN4;
          state <= S_ML;
        end
        S_UP3, S_CONST, S_DN4: begin
          pp    <= pp_clamped;
          state <= S_PROJ;
        end
        S_PROJ: begin
          if (job[2]) begin
            // Direction: |d| * 2^15 / L.
            div_req.num_hi <= '0;
            div_req.num_lo <= {17'd0, d_abs, 15'd0};
            div_req.den    <= {32'd0, path_len};
            ret            <= S_PWB;
            state          <= S_DW;
          end else begin
            op_a  <= job[1] ? sp : pp;
            op_b  <= {32'd0, d_abs};
            ret   <= S_PDIV;
            state <= S_ML;
          end
        end
        S_PDIV: begin
          div_req.num_hi <= '0;
          div_req.num_lo <= acc[63:0];
          div_req.den    <= {32'd0, path_len};
          ret            <= S_PWB;
          state          <= S_DW;
        end
        S_PWB: begin
          unique case (job)
            3'd0:    r_pos_x <= sat32(pos_sum);
            3'd1:    r_pos_y <= sat32(pos_sum);
            3'd2:    r_vel_x <= sat32(proj_val);
            3'd3:    r_vel_y <= sat32(proj_val);
            3'd4:    r_dir_x <= unit_val;
            default: r_dir_y <= unit_val;
          endcase
          if (job == 3'd5) begin
            state <= S_DONE;
          end else begin
            job   <= job + 3'd1;
            state <= S_PROJ;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            o_pos_x      <= r_pos_x;
            o_pos_y      <= r_pos_y;
            o_vel_x      <= r_vel_x;
            o_vel_y      <= r_vel_y;
            o_dir_x      <= r_dir_x;
            o_dir_y      <= r_dir_y;
            o_path_pos   <= pp;
            o_path_speed <= sp;
            o_move_time  <= (tf[63:48] != '0) ? 32'hFFFF_FFFF : tf[47:16];
            if (tick_count != '1) begin
              tick_count <= tick_count + 32'd1;
            end
            state <= S_IDLE;
          end
        end
        S_ML: begin
          mp    <= mul_out;
          state <= S_MH;
        end
        S_MH: begin
          mp    <= mul_out;
          acc   <= {32'd0, mp};
          state <= S_MA;
        end
        S_MA: begin
          acc   <= acc + {mp, 32'd0};
          state <= ret;
        end
        S_DW: begin
          if (div_rsp.done) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pos_x      = o_pos_x;
  assign rsp.pos_y      = o_pos_y;
  assign rsp.vel_x      = o_vel_x;
  assign rsp.vel_y      = o_vel_y;
  assign rsp.dir_x      = o_dir_x;
  assign rsp.dir_y      = o_dir_y;
  assign rsp.path_pos   = o_path_pos;
  assign rsp.path_speed = o_path_speed;
  assign rsp.move_time  = o_move_time;

  // Helpers for the tick counter check.
  logic        tick_zero;
  logic [31:0] tick_inc;
  assign tick_zero = (tick_count == '0);
  assign tick_inc  = tick_count + 32'd1;

  // The latched ramp share never exceeds one half.
  `TLT_ASSERT(a_ramp_cap, ramp_lat <= RAMP_CAP, "latched ramp share above one half")
  // The tick counter only steps by one or restarts from zero.
  `TLT_ASSERT(a_tick_step, $changed(tick_count) |-> tick_zero || $past(tick_inc) == tick_count, "tick jump")
  // The path position handed out never passes the latched length.
  `TLT_ASSERT(a_pp_len, (state == S_DONE) |-> (pp <= path_len), "path position beyond length")
  // The divider is never left running while the sequencer is idle.
  `TLT_ASSERT(a_div_idle, (state == S_IDLE) |-> !div_rsp.busy, "divider busy while idle")

endmodule
